FILE: hdl/jpeg_huffman_bit_decoder_macros.svh
// Assertion helpers for the canonical Huffman bit decoder.
`ifndef JPEG_HUFFMAN_BIT_DECODER_MACROS_SVH
`define JPEG_HUFFMAN_BIT_DECODER_MACROS_SVH

// Condition holds at every edge out of reset.
`define JHBD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Antecedent in this cycle implies consequent in the same cycle.
`define JHBD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define JHBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/jhbd_pkg.sv
package jhbd_pkg;

    localparam int CMD_W    = 3;
    localparam int LIDX_W   = 4;
    localparam int COUNT_W  = 8;
    localparam int SYM_W    = 8;
    localparam int LEN_W    = 5;
    localparam int STATUS_W = 2;
    localparam int CODE_W   = 16;
    localparam int FC_W     = 17;
    localparam int FI_W     = 9;
    localparam int LOADED_W = 9;
    localparam int SUM_W    = 12;

    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_COUNT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FINISH    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DECODE    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_SYMBOL = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BUILT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ERROR  = 2'd3;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [FC_W-1:0]    first_code;
        logic [FI_W-1:0]    first_index;
    } t_tbl_entry;

endpackage

FILE: hdl/jpeg_huffman_bit_decoder.sv
// Canonical Huffman decoder for JPEG DHT tables, one coded bit per item. Clear, set count and
// append symbol are taken in the idle state and do not leave it. Finish walks the per-length
// table memory one code length per cycle, stopping early when the code space overflows, and
// offers the built or rejected status; its last step holds while the output register is
// occupied. A decode bit first reads the table memory entry for the current code length, then
// compares; when a code completes, the symbol memory is read and the fetch state offers the
// symbol. Results sit in an output register, and a new item is taken while an earlier result
// still waits; a result-producing step holds only when the output register is still occupied.
`include "jpeg_huffman_bit_decoder_macros.svh"

module jpeg_huffman_bit_decoder #(
    parameter int MAX_CODE_LENGTH = 16,
    parameter int MAX_SYMBOLS     = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [jhbd_pkg::CMD_W-1:0]    i_command,
    input  logic [jhbd_pkg::LIDX_W-1:0]   i_length_index,
    input  logic [jhbd_pkg::COUNT_W-1:0]  i_count,
    input  logic [jhbd_pkg::SYM_W-1:0]    i_symbol,
    input  logic                          i_bit_req,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [jhbd_pkg::SYM_W-1:0]    o_symbol_res,
    output logic [jhbd_pkg::LEN_W-1:0]    o_code_length,
    output logic [jhbd_pkg::STATUS_W-1:0] o_status
);

    localparam int LW = (MAX_CODE_LENGTH > 1) ? $clog2(MAX_CODE_LENGTH) : 1;
    localparam int SW = $clog2(MAX_SYMBOLS);
    localparam int LEN_W    = jhbd_pkg::LEN_W;
    localparam int COUNT_W  = jhbd_pkg::COUNT_W;
    localparam int SYM_W    = jhbd_pkg::SYM_W;
    localparam int STATUS_W = jhbd_pkg::STATUS_W;
    localparam int CODE_W   = jhbd_pkg::CODE_W;
    localparam int FC_W     = jhbd_pkg::FC_W;
    localparam int FI_W     = jhbd_pkg::FI_W;
    localparam int LOADED_W = jhbd_pkg::LOADED_W;
    localparam int SUM_W    = jhbd_pkg::SUM_W;

    localparam logic [LEN_W-1:0]    MAX_LEN  = LEN_W'(MAX_CODE_LENGTH);
    localparam logic [LOADED_W-1:0] MAX_SYM  = LOADED_W'(MAX_SYMBOLS);
    localparam logic [LOADED_W-1:0] OVER_SYM = LOADED_W'(MAX_SYMBOLS + 1);
    localparam logic [LW-1:0]       LAST_IDX = LW'(MAX_CODE_LENGTH - 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_BUILD  = 2'd1;
    localparam logic [1:0] S_LOOKUP = 2'd2;
    localparam logic [1:0] S_FETCH  = 2'd3;

    jhbd_pkg::t_tbl_entry r_tbl_mem [MAX_CODE_LENGTH];
    logic [SYM_W-1:0]     r_sym_mem [MAX_SYMBOLS];
    jhbd_pkg::t_tbl_entry r_tdata;
    logic [SYM_W-1:0]     r_sym_rdata;

    logic [1:0]          r_state, n_state;
    logic                r_out_valid, n_out_valid;
    logic [SYM_W-1:0]    r_out_sym, n_out_sym;
    logic [LEN_W-1:0]    r_out_len, n_out_len;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic                r_table_valid, n_table_valid;
    logic [LOADED_W-1:0] r_loaded, n_loaded;
    logic [COUNT_W-1:0]  r_counts [MAX_CODE_LENGTH];
    logic [COUNT_W-1:0]  n_counts [MAX_CODE_LENGTH];
    logic [CODE_W-1:0]   r_acc, n_acc;
    logic [LEN_W-1:0]    r_bits, n_bits;
    logic [LW-1:0]       r_idx, n_idx;
    logic [FC_W-1:0]     r_code, n_code;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [LEN_W-1:0]    r_lmax, n_lmax;
    logic [CODE_W-1:0]   r_last, n_last;
    logic [LEN_W-1:0]    r_hit_len, n_hit_len;

    logic                accept;
    logic                out_free;
    logic                sym_we;
    logic                tbl_we;
    logic [COUNT_W-1:0]  b_cnt;
    logic [FC_W:0]       b_code_sum;
    logic [FC_W:0]       b_limit;
    logic                b_over;
    logic [SUM_W-1:0]    b_sum;
    logic                b_done;
    logic                b_ok;
    logic                b_advance;
    logic [FC_W-1:0]     l_diff;
    logic                l_hit;
    logic [FI_W-1:0]     l_idx;
    logic [LEN_W-1:0]    l_shift;
    logic [CODE_W-1:0]   l_bound;
    logic                l_err;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && (r_state == S_IDLE);
    assign sym_we   = accept && (i_command == jhbd_pkg::CMD_APPEND) && (r_loaded < MAX_SYM);

    assign o_valid       = r_out_valid;
    assign o_symbol_res  = r_out_sym;
    assign o_code_length = r_out_len;
    assign o_status      = r_out_status;

    assign b_cnt      = r_counts[r_idx];
    assign b_code_sum = {1'b0, r_code} + (FC_W+1)'(b_cnt);
    assign b_limit    = (FC_W+1)'(1) << (LEN_W'(r_idx) + LEN_W'(1));
    assign b_over     = b_code_sum > b_limit;
    assign b_sum      = r_sum + SUM_W'(b_cnt);
    assign b_done     = b_over || (r_idx == LAST_IDX);
    assign b_ok       = !b_over && (b_sum == SUM_W'(r_loaded)) && (r_loaded <= MAX_SYM);
    assign b_advance  = (r_state == S_BUILD) && (!b_done || out_free);
    assign tbl_we     = b_advance;

    assign l_diff  = {1'b0, r_acc} - r_tdata.first_code;
    assign l_hit   = (r_tdata.count != '0) && ({1'b0, r_acc} >= r_tdata.first_code)
                     && (l_diff < FC_W'(r_tdata.count));
    assign l_idx   = r_tdata.first_index + l_diff[FI_W-1:0];
    assign l_shift = r_lmax - r_bits;
    assign l_bound = r_last >> l_shift;
    assign l_err   = !r_table_valid || (r_lmax == '0) || (r_bits > r_lmax)
                     || (!l_hit && ((r_bits >= r_lmax) || (r_acc > l_bound)));

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && i_stall;
        n_out_sym     = r_out_sym;
        n_out_len     = r_out_len;
        n_out_status  = r_out_status;
        n_table_valid = r_table_valid;
        n_loaded      = r_loaded;
        n_counts      = r_counts;
        n_acc         = r_acc;
        n_bits        = r_bits;
        n_idx         = r_idx;
        n_code        = r_code;
        n_sum         = r_sum;
        n_lmax        = r_lmax;
        n_last        = r_last;
        n_hit_len     = r_hit_len;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_command)
                        jhbd_pkg::CMD_CLEAR: begin
                            n_counts      = '{default: '0};
                            n_loaded      = '0;
                            n_table_valid = 1'b0;
                            n_acc         = '0;
                            n_bits        = '0;
                        end
                        jhbd_pkg::CMD_SET_COUNT: begin
                            if (LEN_W'(i_length_index) < MAX_LEN) begin
                                n_counts[i_length_index[LW-1:0]] = i_count;
                            end
                            n_table_valid = 1'b0;
                            n_acc         = '0;
                            n_bits        = '0;
                        end
                        jhbd_pkg::CMD_APPEND: begin
                            n_loaded      = (r_loaded < MAX_SYM) ? r_loaded + LOADED_W'(1)
                                                                 : OVER_SYM;
                            n_table_valid = 1'b0;
                            n_acc         = '0;
                            n_bits        = '0;
                        end
                        jhbd_pkg::CMD_FINISH: begin
                            n_state       = S_BUILD;
                            n_table_valid = 1'b0;
                            n_idx         = '0;
                            n_code        = '0;
                            n_sum         = '0;
                            n_lmax        = '0;
                            n_acc         = '0;
                            n_bits        = '0;
                        end
                        jhbd_pkg::CMD_DECODE: begin
                            n_state = S_LOOKUP;
                            if (r_table_valid) begin
                                n_acc  = {r_acc[CODE_W-2:0], i_bit_req};
                                n_bits = r_bits + LEN_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_BUILD: begin
                if (b_advance) begin
                    n_code = {b_code_sum[FC_W-2:0], 1'b0};
                    n_sum  = b_sum;
                    n_idx  = r_idx + LW'(1);
                    if (b_cnt != '0) begin
                        n_lmax = LEN_W'(r_idx) + LEN_W'(1);
                        n_last = CODE_W'(b_code_sum - (FC_W+1)'(1));
                    end
                    if (b_done) begin
                        n_state       = S_IDLE;
                        n_table_valid = b_ok;
                        n_out_valid   = 1'b1;
                        n_out_sym     = '0;
                        n_out_len     = '0;
                        n_out_status  = b_ok ? jhbd_pkg::ST_BUILT : jhbd_pkg::ST_REJECT;
                    end
                end
            end
            S_LOOKUP: begin
                if (!r_table_valid || l_err) begin
                    if (out_free) begin
                        n_state      = S_IDLE;
                        n_out_valid  = 1'b1;
                        n_out_sym    = '0;
                        n_out_len    = r_table_valid ? r_bits : '0;
                        n_out_status = jhbd_pkg::ST_ERROR;
                        n_acc        = '0;
                        n_bits       = '0;
                    end
                end else if (l_hit) begin
                    n_state   = S_FETCH;
                    n_hit_len = r_bits;
                    n_acc     = '0;
                    n_bits    = '0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FETCH: begin
                if (out_free) begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_sym    = r_sym_rdata;
                    n_out_len    = r_hit_len;
                    n_out_status = jhbd_pkg::ST_SYMBOL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl_mem[r_idx] <= '{count: b_cnt, first_code: r_code,
                                  first_index: r_sum[FI_W-1:0]};
        end
        if (r_state == S_IDLE) begin
            r_tdata <= r_tbl_mem[r_bits[LW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sym_we) begin
            r_sym_mem[r_loaded[SW-1:0]] <= i_symbol;
        end
        if (r_state == S_LOOKUP) begin
            r_sym_rdata <= r_sym_mem[l_idx[SW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_table_valid <= 1'b0;
            r_loaded      <= '0;
            r_counts      <= '{default: '0};
            r_acc         <= '0;
            r_bits        <= '0;
            r_idx         <= '0;
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_table_valid <= n_table_valid;
            r_loaded      <= n_loaded;
            r_counts      <= n_counts;
            r_acc         <= n_acc;
            r_bits        <= n_bits;
            r_idx         <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_sym    <= n_out_sym;
        r_out_len    <= n_out_len;
        r_out_status <= n_out_status;
        r_code       <= n_code;
        r_sum        <= n_sum;
        r_lmax       <= n_lmax;
        r_last       <= n_last;
        r_hit_len    <= n_hit_len;
    end

    `JHBD_ASSERT_IMPLY(a_build_invalid, r_state == S_BUILD, !r_table_valid, "table valid during build")
    `JHBD_ASSERT_IMPLY(a_walk_bound, r_table_valid && (r_state == S_IDLE), (r_bits == '0) || (r_bits < r_lmax), "walk deeper than longest code")
    `JHBD_ASSERT_IMPLY(a_fetch_home, r_state == S_FETCH, (r_bits == '0) && (r_acc == '0), "walk not at root after a hit")
    `JHBD_ASSERT_ALWAYS(a_loaded_cap, r_loaded <= OVER_SYM, "symbol count past cap")
    `JHBD_ASSERT_NEXT(a_out_len, r_state == S_FETCH && out_free, (o_code_length != '0) && (o_code_length <= MAX_LEN), "decoded length out of range")

endmodule

FILE: test/jpeg_huffman_bit_decoder_checker.sv
module jpeg_huffman_bit_decoder_checker
    import jhbd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [LIDX_W-1:0]   i_length_index,
    input  logic [COUNT_W-1:0]  i_count,
    input  logic [SYM_W-1:0]    i_symbol,
    input  logic                i_bit_req,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [SYM_W-1:0]    i_symbol_res,
    input  logic [LEN_W-1:0]    i_code_length,
    input  logic [STATUS_W-1:0] i_status,
    output int                  o_fail_count,
    output int                  o_outstanding,
    output int                  o_decoded,
    output int                  o_built,
    output int                  o_rejected,
    output int                  o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN  = 16;
    localparam int MAX_SYMS = 256;

    typedef struct packed {
        logic [SYM_W-1:0]    symbol_res;
        logic [LEN_W-1:0]    code_length;
        logic [STATUS_W-1:0] status;
    } t_huff_result;

    logic [COUNT_W-1:0]  len_count [MAX_LEN];
    logic [SYM_W-1:0]    sym_mem [MAX_SYMS];
    logic [FC_W-1:0]     base_code [MAX_LEN];
    logic [FI_W-1:0]     base_index [MAX_LEN];
    logic [LOADED_W-1:0] sym_loaded;
    logic                table_ok;
    logic [CODE_W-1:0]   code_acc;
    logic [LEN_W-1:0]    code_bits;
    t_huff_result        awaited_results [$];
    int                  fail_cnt;
    int                  decoded_cnt;
    int                  built_cnt;
    int                  rejected_cnt;
    int                  error_cnt;

    function automatic void go_root();
        code_acc  = '0;
        code_bits = '0;
    endfunction

    function automatic bit rebuild_bases();
        int code;
        int total;
        int k;
        code  = 0;
        total = 0;
        for (k = 0; k < MAX_LEN; k++) begin
            base_code[k]  = code[FC_W-1:0];
            base_index[k] = total[FI_W-1:0];
            total += int'(len_count[k]);
            code  += int'(len_count[k]);
            if (code > (1 << (k + 1))) return 1'b0;
            code = code << 1;
        end
        return (total == int'(sym_loaded)) && (int'(sym_loaded) <= MAX_SYMS);
    endfunction

    function automatic bit predict_item(
        input  logic [CMD_W-1:0]   cmd,
        input  logic [LIDX_W-1:0]  lidx,
        input  logic [COUNT_W-1:0] cnt,
        input  logic [SYM_W-1:0]   sym,
        input  logic               bit_in,
        output t_huff_result       res
    );
        int len;
        int lmax;
        int acc;
        int first;
        int span;
        int last;
        int idx;
        res = '{symbol_res: '0, code_length: '0, status: ST_ERROR};
        case (cmd)
            CMD_CLEAR: begin
                foreach (len_count[k]) len_count[k] = '0;
                sym_loaded = '0;
                table_ok   = 1'b0;
                go_root();
                return 1'b0;
            end
            CMD_SET_COUNT: begin
                len_count[lidx] = cnt;
                table_ok        = 1'b0;
                go_root();
                return 1'b0;
            end
            CMD_APPEND: begin
                if (sym_loaded < MAX_SYMS) begin
                    sym_mem[sym_loaded[SYM_W-1:0]] = sym;
                    sym_loaded++;
                end else begin
                    sym_loaded = LOADED_W'(MAX_SYMS + 1);
                end
                table_ok = 1'b0;
                go_root();
                return 1'b0;
            end
            CMD_FINISH: begin
                table_ok = rebuild_bases();
                go_root();
                res.status = table_ok ? ST_BUILT : ST_REJECT;
                return 1'b1;
            end
            CMD_DECODE: begin
                if (!table_ok) begin
                    go_root();
                    return 1'b1;
                end
                code_acc  = {code_acc[CODE_W-2:0], bit_in};
                code_bits = code_bits + 1'b1;
                len       = int'(code_bits);
                lmax      = 0;
                foreach (len_count[k]) begin
                    if (len_count[k] != 0) lmax = k + 1;
                end
                res.code_length = code_bits;
                if (lmax == 0 || len > lmax) begin
                    go_root();
                    return 1'b1;
                end
                acc   = int'(code_acc);
                first = int'(base_code[len - 1]);
                span  = int'(len_count[len - 1]);
                if (span != 0 && acc >= first && acc - first < span) begin
                    idx            = int'(base_index[len - 1]) + acc - first;
                    res.symbol_res = sym_mem[idx[SYM_W-1:0]];
                    res.status     = ST_SYMBOL;
                    go_root();
                    return 1'b1;
                end
                if (len >= lmax) begin
                    go_root();
                    return 1'b1;
                end
                last = int'(base_code[lmax - 1]) + int'(len_count[lmax - 1]) - 1;
                if (acc > (last >> (lmax - len))) begin
                    go_root();
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_huff_result got;
        t_huff_result want;
        if (!i_rst_n) begin
            foreach (len_count[k]) len_count[k] = '0;
            foreach (sym_mem[k]) sym_mem[k] = '0;
            foreach (base_code[k]) base_code[k] = '0;
            foreach (base_index[k]) base_index[k] = '0;
            sym_loaded = '0;
            table_ok   = 1'b0;
            go_root();
            awaited_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{symbol_res: i_symbol_res, code_length: i_code_length, status: i_status};
                if (awaited_results.size() == 0) begin
                    fail_cnt++;
                    $error("unexpected result: symbol_res %0d, code_length %0d, status %0d",
                           got.symbol_res, got.code_length, got.status);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.symbol_res !== want.symbol_res) begin
                        fail_cnt++;
                        $error("symbol_res: expected %0d, actual %0d",
                               want.symbol_res, got.symbol_res);
                    end
                    if (got.code_length !== want.code_length) begin
                        fail_cnt++;
                        $error("code_length: expected %0d, actual %0d",
                               want.code_length, got.code_length);
                    end
                    if (got.status !== want.status) begin
                        fail_cnt++;
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (predict_item(i_command, i_length_index, i_count, i_symbol, i_bit_req,
                                 want)) begin
                    awaited_results.push_back(want);
                    case (want.status)
                        ST_SYMBOL: decoded_cnt++;
                        ST_BUILT:  built_cnt++;
                        ST_REJECT: rejected_cnt++;
                        default:   error_cnt++;
                    endcase
                end
            end
        end
        o_fail_count  <= fail_cnt;
        o_outstanding <= awaited_results.size();
        o_decoded     <= decoded_cnt;
        o_built       <= built_cnt;
        o_rejected    <= rejected_cnt;
        o_errors      <= error_cnt;
    end

endmodule

FILE: test/jpeg_huffman_bit_decoder_tb.sv
module jpeg_huffman_bit_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jhbd_pkg::*;

    localparam int N_ITEMS        = 1750;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int ANY            = -1;
    localparam int CMD_TOP        = (1 << CMD_W) - 1;

    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BEAT} t_rx_mode;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_valid        = 1'b0;
    logic [CMD_W-1:0]    i_command      = '0;
    logic [LIDX_W-1:0]   i_length_index = '0;
    logic [COUNT_W-1:0]  i_count        = '0;
    logic [SYM_W-1:0]    i_symbol       = '0;
    logic                i_bit_req      = 1'b0;
    logic                i_stall        = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [SYM_W-1:0]    o_symbol_res;
    logic [LEN_W-1:0]    o_code_length;
    logic [STATUS_W-1:0] o_status;

    int       fail_count;
    int       outstanding;
    int       n_decoded;
    int       n_built;
    int       n_rejected;
    int       n_errors;
    int       items_sent  = 0;
    int       burst_left  = 0;
    int       hold_asks   = 0;
    int       hold_seen   = 0;
    int       hold_left   = 0;
    int       stall_left  = 0;
    int       stall_phase = 0;
    t_rx_mode stall_mode  = RX_FREE;
    int       gen_count [16];
    int       gen_total   = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    jpeg_huffman_bit_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_length_index (i_length_index),
        .i_count        (i_count),
        .i_symbol       (i_symbol),
        .i_bit_req      (i_bit_req),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_symbol_res   (o_symbol_res),
        .o_code_length  (o_code_length),
        .o_status       (o_status)
    );

    jpeg_huffman_bit_decoder_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_command      (i_command),
        .i_length_index (i_length_index),
        .i_count        (i_count),
        .i_symbol       (i_symbol),
        .i_bit_req      (i_bit_req),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_symbol_res   (o_symbol_res),
        .i_code_length  (o_code_length),
        .i_status       (o_status),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding),
        .o_decoded      (n_decoded),
        .o_built        (n_built),
        .o_rejected     (n_rejected),
        .o_errors       (n_errors)
    );

    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES - 1;
            i_stall   <= 1'b1;
        end else begin
            if (stall_left == 0) begin
                stall_mode <= t_rx_mode'($urandom_range(0, 3));
                stall_left <= $urandom_range(16, 160);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                RX_FREE:  i_stall <= 1'b0;
                RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                default:  i_stall <= ((stall_phase % 7) < 3);
            endcase
        end
    end

    task automatic send(input logic [CMD_W-1:0] cmd, input int lidx, input int cnt,
                        input int sym, input int bit_in);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_length_index <= (lidx < 0) ? LIDX_W'($urandom) : LIDX_W'(lidx);
        i_count        <= (cnt < 0) ? COUNT_W'($urandom) : COUNT_W'(cnt);
        i_symbol       <= (sym < 0) ? SYM_W'($urandom) : SYM_W'(sym);
        i_bit_req      <= (bit_in < 0) ? 1'($urandom) : 1'(bit_in);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (cmd <= CMD_DECODE) items_sent++;
    endtask

    function automatic void make_counts(input int lmax, input int cap, input bit complete);
        int code;
        int room;
        int lim;
        int c;
        int k;
        code      = 0;
        gen_total = 0;
        for (k = 0; k < 16; k++) begin
            room = (1 << (k + 1)) - code;
            lim  = room;
            if (lim > 255) lim = 255;
            if (lim > cap - gen_total) lim = cap - gen_total;
            if (k >= lmax || lim <= 0) begin
                c = 0;
            end else if (k == lmax - 1) begin
                c = complete ? lim : $urandom_range(1, lim);
            end else begin
                lim = lim - 1;
                c   = ($urandom_range(0, 3) != 0 && lim > 2) ? $urandom_range(0, 2)
                                                             : $urandom_range(0, lim);
            end
            gen_count[k] = c;
            gen_total   += c;
            code         = (code + c) << 1;
        end
    endfunction

    task automatic load_table(input bit do_clear, input int extra);
        int k;
        if (do_clear) send(CMD_CLEAR, ANY, ANY, ANY, ANY);
        for (k = 0; k < 16; k++) begin
            if (gen_count[k] != 0 || !do_clear || $urandom_range(0, 2) == 0)
                send(CMD_SET_COUNT, k, gen_count[k], ANY, ANY);
        end
        repeat (gen_total + extra) send(CMD_APPEND, ANY, ANY, ANY, ANY);
        send(CMD_FINISH, ANY, ANY, ANY, ANY);
    endtask

    task automatic send_codeword(input int pick);
        int code;
        int base;
        int len;
        int c;
        int k;
        code = 0;
        base = 0;
        len  = 0;
        c    = 0;
        for (k = 0; k < 16 && len == 0; k++) begin
            if (pick < base + gen_count[k]) begin
                c   = code + pick - base;
                len = k + 1;
            end else begin
                base += gen_count[k];
                code  = (code + gen_count[k]) << 1;
            end
        end
        for (k = len - 1; k >= 0; k--) send(CMD_DECODE, ANY, ANY, ANY, (c >> k) & 1);
    endtask

    task automatic decode_run(input int n);
        int stop;
        stop = items_sent + n;
        while (items_sent < stop) begin
            if ($urandom_range(0, 49) == 0)
                send(CMD_W'($urandom_range(CMD_DECODE + 1, CMD_TOP)), ANY, ANY, ANY, ANY);
            else if (gen_total == 0 || $urandom_range(0, 3) == 0)
                send(CMD_DECODE, ANY, ANY, ANY, ANY);
            else
                send_codeword($urandom_range(0, gen_total - 1));
        end
    endtask

    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle = 0;
            else
                idle++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int  roll;
        int  variant;
        int  pressure_count;
        int  big_appends;
        bit  complete;
        pressure_count = 0;
        big_appends    = 0;
        foreach (gen_count[k]) gen_count[k] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send(CMD_DECODE, ANY, ANY, ANY, 1);
        send(CMD_W'(CMD_DECODE + 1), ANY, ANY, ANY, ANY);
        send(CMD_W'(CMD_TOP), ANY, ANY, ANY, ANY);
        send(CMD_FINISH, ANY, ANY, ANY, ANY);
        send(CMD_DECODE, ANY, ANY, ANY, 0);
        send(CMD_SET_COUNT, 0, 2, ANY, ANY);
        send(CMD_APPEND, ANY, ANY, 8'h00, ANY);
        send(CMD_APPEND, ANY, ANY, 8'hFF, ANY);
        send(CMD_FINISH, ANY, ANY, ANY, ANY);
        send(CMD_DECODE, ANY, ANY, ANY, 0);
        send(CMD_DECODE, ANY, ANY, ANY, 1);
        send(CMD_SET_COUNT, 15, 255, ANY, ANY);
        send(CMD_FINISH, ANY, ANY, ANY, ANY);
        send(CMD_CLEAR, ANY, ANY, ANY, ANY);
        send(CMD_SET_COUNT, 0, 1, ANY, ANY);
        send(CMD_APPEND, ANY, ANY, 8'h5A, ANY);
        send(CMD_FINISH, ANY, ANY, ANY, ANY);
        send(CMD_DECODE, ANY, ANY, ANY, 1);
        send(CMD_DECODE, ANY, ANY, ANY, 0);
        send(CMD_SET_COUNT, 0, 1, ANY, ANY);
        send(CMD_DECODE, ANY, ANY, ANY, 0);
        send(CMD_APPEND, ANY, ANY, 8'h11, ANY);
        send(CMD_FINISH, ANY, ANY, ANY, ANY);

        while (items_sent < N_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                complete = ($urandom_range(0, 2) != 0);
                make_counts(($urandom_range(0, 99) < 85) ? $urandom_range(1, 8)
                                                         : $urandom_range(9, 16),
                            ($urandom_range(0, 14) == 0) ? 256 : $urandom_range(2, 24),
                            complete);
                load_table(1'b1, 0);
                if (pressure_count == 0 || (pressure_count == 1 && items_sent > N_ITEMS / 2)) begin
                    hold_asks <= hold_asks + 1;
                    pressure_count++;
                    decode_run(150);
                end else begin
                    decode_run($urandom_range(30, 120));
                end
            end else if (roll < 75) begin
                make_counts($urandom_range(1, 8), $urandom_range(2, 20), 1'b1);
                variant = $urandom_range(0, 3);
                case (variant)
                    0: load_table(1'b1, 1);
                    1: load_table(1'b1, (gen_total > 0) ? -1 : 1);
                    2: begin
                        load_table(1'b1, 0);
                        send(CMD_SET_COUNT, 0, $urandom_range(3, 255), ANY, ANY);
                        send(CMD_FINISH, ANY, ANY, ANY, ANY);
                    end
                    default: load_table(1'b0, 0);
                endcase
                decode_run($urandom_range(3, 10));
            end else if (roll < 80 && big_appends < 2) begin
                big_appends++;
                make_counts($urandom_range(8, 12), 256, 1'b1);
                load_table(1'b1, 257 - gen_total + $urandom_range(0, 3));
                decode_run($urandom_range(3, 8));
            end else begin
                make_counts($urandom_range(2, 8), $urandom_range(3, 20), 1'b1);
                load_table(1'b1, 0);
                decode_run($urandom_range(3, 12));
                variant = $urandom_range(0, 2);
                case (variant)
                    0: begin
                        roll = $urandom_range(0, 15);
                        send(CMD_SET_COUNT, roll, gen_count[roll], ANY, ANY);
                    end
                    1: send(CMD_APPEND, ANY, ANY, ANY, ANY);
                    default: send(CMD_CLEAR, ANY, ANY, ANY, ANY);
                endcase
                decode_run($urandom_range(2, 6));
                send(CMD_FINISH, ANY, ANY, ANY, ANY);
                decode_run($urandom_range(10, 30));
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run covered %0d items: %0d symbols decoded, %0d decode errors,",
                 items_sent, n_decoded, n_errors);
        $display("%0d tables built, %0d tables rejected", n_built, n_rejected);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/jhbd_pkg.sv
hdl/jpeg_huffman_bit_decoder.sv
test/jpeg_huffman_bit_decoder_checker.sv
test/jpeg_huffman_bit_decoder_tb.sv
